@@ rtl/liv_pkg.sv @@
// liv_pkg: shared types and constants for the ipv4 lease validator
// holds verdict codes, config register indexes and address range limits
// no dependencies
package liv_pkg;

    typedef enum logic [1:0] {
        VERDICT_VALID    = 2'd0,
        VERDICT_MASK     = 2'd1,
        VERDICT_GATEWAY  = 2'd2,
        VERDICT_CONFLICT = 2'd3
    } verdict_t;

    // config register indexes
    localparam logic CfgLanAddress = 1'b0;
    localparam logic CfgLanNetmask = 1'b1;

    localparam logic [31:0] LanAddressReset = 32'hc0a8_0101;
    localparam logic [31:0] LanNetmaskReset = 32'hffff_ff00;

    // shared address space and link-local ranges
    localparam logic [31:0] CgnatLow  = 32'h6440_0000;
    localparam logic [31:0] CgnatHigh = 32'h647f_ffff;
    localparam logic [31:0] LinklLow  = 32'ha9fe_0000;
    localparam logic [31:0] LinklHigh = 32'ha9fe_ffff;

    localparam logic [7:0]  ClassDOct = 8'd224;
    localparam logic [7:0]  LoopOct   = 8'd127;
    localparam logic [31:0] MinHosts  = 32'd3;

    typedef struct packed {
        logic       ok;
        logic [5:0] prefix;
    } mask_info_t;

endpackage

@@ rtl/liv_mask_check.sv @@
// liv_mask_check: subnet mask shape check and prefix length count
// depends on liv_pkg
module liv_mask_check
(
    input  logic [31:0]         mask,
    output liv_pkg::mask_info_t info
);

    logic [31:0] host;
    logic [31:0] host_inc;
    logic        contiguous;
    logic [2:0]  nib_cnt [8];
    logic [3:0]  sum_l1 [4];
    logic [4:0]  sum_l2 [2];
    logic [5:0]  ones;

    always_comb
    begin
        host       = ~mask;
        host_inc   = host + 32'd1;
        contiguous = ((host & host_inc) == 32'd0);
    end

    // popcount of the mask, equal to the prefix once it is contiguous
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            nib_cnt[i] = {2'b00, mask[4*i]} + {2'b00, mask[4*i+1]}
                       + {2'b00, mask[4*i+2]} + {2'b00, mask[4*i+3]};
        end
        for (int i = 0; i < 4; i++)
        begin
            sum_l1[i] = {1'b0, nib_cnt[2*i]} + {1'b0, nib_cnt[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            sum_l2[i] = {1'b0, sum_l1[2*i]} + {1'b0, sum_l1[2*i+1]};
        end
        ones = {1'b0, sum_l2[0]} + {1'b0, sum_l2[1]};
    end

    always_comb
    begin
        info.ok     = contiguous && (mask != 32'd0) && (host >= liv_pkg::MinHosts);
        info.prefix = ones;
    end

endmodule

@@ rtl/liv_lease_eval.sv @@
// liv_lease_eval: gateway, host part and subnet overlap checks, verdict select
// depends on liv_pkg and liv_mask_check
module liv_lease_eval
(
    input  logic [31:0]       lease_address,
    input  logic [31:0]       lease_netmask,
    input  logic [31:0]       gateway_address,
    input  logic [31:0]       lan_address,
    input  logic [31:0]       lan_netmask,
    output liv_pkg::verdict_t verdict,
    output logic [5:0]        prefix_length
);

    liv_pkg::mask_info_t mask_info;

    logic [31:0] host;
    logic [31:0] ip_host;
    logic [31:0] gw_host;
    logic [7:0]  ip_oct;
    logic [7:0]  gw_oct;
    logic        gw_bad;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] lan_lo;
    logic [31:0] lan_hi;
    logic        conflict;

    liv_mask_check u_mask
    (
        .mask (lease_netmask),
        .info (mask_info)
    );

    always_comb
    begin
        host    = ~lease_netmask;
        ip_host = lease_address & host;
        gw_host = gateway_address & host;
        ip_oct  = lease_address[31:24];
        gw_oct  = gateway_address[31:24];

        gw_bad = ((lease_address & lease_netmask) != (gateway_address & lease_netmask))
              || (lease_address == gateway_address)
              || (ip_host == 32'd0) || (ip_host == host)
              || (gw_host == 32'd0) || (gw_host == host)
              || (ip_oct inside {8'd0, liv_pkg::LoopOct, [liv_pkg::ClassDOct:8'hff]})
              || (gw_oct inside {8'd0, liv_pkg::LoopOct, [liv_pkg::ClassDOct:8'hff]});

        lo     = lease_address & lease_netmask;
        hi     = lo | host;
        lan_lo = lan_address & lan_netmask;
        lan_hi = lan_lo | ~lan_netmask;

        conflict = ((lo <= lan_hi) && (hi >= lan_lo))
                || ((lo <= liv_pkg::CgnatHigh) && (hi >= liv_pkg::CgnatLow))
                || ((lo <= liv_pkg::LinklHigh) && (hi >= liv_pkg::LinklLow));

        prefix_length = 6'd0;
        if (!mask_info.ok)
        begin
            verdict = liv_pkg::VERDICT_MASK;
        end
        else if (gw_bad)
        begin
            verdict = liv_pkg::VERDICT_GATEWAY;
        end
        else if (conflict)
        begin
            verdict = liv_pkg::VERDICT_CONFLICT;
        end
        else
        begin
            verdict       = liv_pkg::VERDICT_VALID;
            prefix_length = mask_info.prefix;
        end
    end

endmodule

@@ rtl/ipv4_lease_validator.sv @@
// ipv4_lease_validator: top level, input and result registers plus lan config
// depends on liv_pkg and liv_lease_eval
//
// usage
//   - a lease transfer is taken at a rising edge with start high and busy low;
//     busy is held low, so a lease can be offered in every cycle
//   - the lease fields are captured in an input register; the checks run in
//     one combinational pass through liv_lease_eval (mask shape, gateway and
//     host part checks, overlap against the lan, shared and link-local
//     ranges) and land in a result register
//   - path: the lease passes the input register, then the result register,
//     whose loading raises done together with verdict and prefix_length; throughput one
//     lease a cycle, set by the single registered evaluation stage
//   - results are not held: the receiver takes each one in its done cycle and
//     cannot stall the block
//   - configuration: cfg_write with cfg_index 0 writes lan_address, index 1
//     writes lan_netmask; writes take effect at the next edge; the user must keep
//     the block idle for them, which the block itself does not enforce
//   - reset (rst_n low, asynchronous) drops any lease in flight, clears done
//     and restores the lan address 192.168.1.1 with mask 255.255.255.0
module ipv4_lease_validator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] lease_address,
    input  logic [31:0] lease_netmask,
    input  logic [31:0] gateway_address,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    output logic        done,
    output logic [1:0]  verdict,
    output logic [5:0]  prefix_length
);

    // lan configuration
    logic [31:0] lan_address_reg;
    logic [31:0] lan_netmask_reg;

    // input register stage
    logic        in_valid_reg;
    logic [31:0] address_reg;
    logic [31:0] netmask_reg;
    logic [31:0] gateway_reg;

    // evaluation result
    liv_pkg::verdict_t verdict_next;
    logic [5:0]        prefix_next;

    // result register stage
    logic        done_reg;
    logic [1:0]  verdict_reg;
    logic [5:0]  prefix_reg;

    // never stalls: every start is a transfer
    assign busy = 1'b0;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lan_address_reg <= liv_pkg::LanAddressReset;
            lan_netmask_reg <= liv_pkg::LanNetmaskReset;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                liv_pkg::CfgLanAddress: lan_address_reg <= cfg_wdata;
                liv_pkg::CfgLanNetmask: lan_netmask_reg <= cfg_wdata;
                default:                lan_address_reg <= lan_address_reg;
            endcase
        end
    end

    // capture the lease on a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            address_reg <= lease_address;
            netmask_reg <= lease_netmask;
            gateway_reg <= gateway_address;
        end
    end

    liv_lease_eval u_eval
    (
        .lease_address   (address_reg),
        .lease_netmask   (netmask_reg),
        .gateway_address (gateway_reg),
        .lan_address     (lan_address_reg),
        .lan_netmask     (lan_netmask_reg),
        .verdict         (verdict_next),
        .prefix_length   (prefix_next)
    );

    // result register, one-cycle strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            verdict_reg <= verdict_next;
            prefix_reg  <= prefix_next;
        end
    end

    assign done          = done_reg;
    assign verdict       = verdict_reg;
    assign prefix_length = prefix_reg;

endmodule

@@ rtl/liv_checker.sv @@
// liv_checker: port-level assertions for ipv4_lease_validator, bound to the top
// depends on liv_pkg
module liv_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  verdict,
    input logic [5:0]  prefix_length
);

    // every transfer gives a result, through the input and result registers
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("lease transfer without a result");

    // no result without a matching transfer before it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without a lease transfer");

    // prefix only reported for a valid lease
    a_prefix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (verdict != liv_pkg::VERDICT_VALID)) |-> (prefix_length == 6'd0))
        else $error("prefix length set on a rejected lease");

    // a valid lease has a nonzero mask with at least two host bits
    a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (verdict == liv_pkg::VERDICT_VALID))
            |-> ((prefix_length != 6'd0) && (prefix_length <= 6'd30)))
        else $error("prefix length out of range on a valid lease");

endmodule

bind ipv4_lease_validator liv_checker u_liv_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .verdict       (verdict),
    .prefix_length (prefix_length)
);

@@ tb/ipv4_lease_validator_tb.sv @@
// ipv4_lease_validator_tb: self-checking testbench for the ipv4 lease validator
// predicts verdict and prefix length for each lease and checks every done pulse
// depends on liv_pkg and ipv4_lease_validator
module ipv4_lease_validator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // hard stop, far beyond the slowest correct run
    localparam int CycleLimit = 200_000;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] netmask;
        logic [31:0] gateway;
    } lease_t;

    typedef struct packed {
        liv_pkg::verdict_t verdict;
        logic [5:0]        prefix;
    } lease_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] lease_address = '0;
    logic [31:0] lease_netmask = '0;
    logic [31:0] gateway_address = '0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        done;
    logic [1:0]  verdict;
    logic [5:0]  prefix_length;

    // leases waiting to be offered, and verdicts still owed by the block
    lease_t         lease_queue[$];
    lease_verdict_t verdict_queue[$];

    // our own copy of the lan registers, changed only while the block is idle
    logic [31:0] lan_address_now = liv_pkg::LanAddressReset;
    logic [31:0] lan_netmask_now = liv_pkg::LanNetmaskReset;

    int idle_pct = 0;
    int idle_left = 0;
    int error_count = 0;
    int cycle_count = 0;

    ipv4_lease_validator uut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .lease_address   (lease_address),
        .lease_netmask   (lease_netmask),
        .gateway_address (gateway_address),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .done            (done),
        .verdict         (verdict),
        .prefix_length   (prefix_length)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // verdict prediction
    // ------------------------------------------------------------------

    // first octet zero, loopback, or multicast and above
    function automatic logic octet_reserved(logic [7:0] octet);
        return octet == 8'd0 || octet == liv_pkg::LoopOct || octet >= liv_pkg::ClassDOct;
    endfunction

    // host part all zeros (network) or all ones (broadcast)
    function automatic logic host_edge(logic [31:0] addr, logic [31:0] host_bits);
        return (addr & host_bits) == '0 || (addr & host_bits) == host_bits;
    endfunction

    function automatic logic ranges_meet(logic [31:0] lo, logic [31:0] hi,
                                         logic [31:0] other_lo, logic [31:0] other_hi);
        return lo <= other_hi && hi >= other_lo;
    endfunction

    function automatic lease_verdict_t judge_lease(logic [31:0] addr,
                                                   logic [31:0] netmask,
                                                   logic [31:0] gateway);
        logic [31:0]    host_bits;
        logic [31:0]    net_low;
        logic [31:0]    net_high;
        logic [31:0]    lan_low;
        logic [31:0]    lan_high;
        lease_verdict_t outcome;
        host_bits = ~netmask;
        net_low   = addr & netmask;
        net_high  = net_low | host_bits;
        // the lan mask is taken as written, contiguous or not
        lan_low   = lan_address_now & lan_netmask_now;
        lan_high  = lan_low | ~lan_netmask_now;
        outcome.verdict = liv_pkg::VERDICT_VALID;
        outcome.prefix  = '0;
        // host bits must be a run of ones from bit 0, at least two of them
        if ((host_bits & (host_bits + 32'd1)) != '0 || netmask == '0 ||
            host_bits < liv_pkg::MinHosts)
            outcome.verdict = liv_pkg::VERDICT_MASK;
        else if (net_low != (gateway & netmask) || addr == gateway ||
                 host_edge(addr, host_bits) || host_edge(gateway, host_bits) ||
                 octet_reserved(addr[31:24]) || octet_reserved(gateway[31:24]))
            outcome.verdict = liv_pkg::VERDICT_GATEWAY;
        else if (ranges_meet(net_low, net_high, lan_low, lan_high) ||
                 ranges_meet(net_low, net_high, liv_pkg::CgnatLow, liv_pkg::CgnatHigh) ||
                 ranges_meet(net_low, net_high, liv_pkg::LinklLow, liv_pkg::LinklHigh))
            outcome.verdict = liv_pkg::VERDICT_CONFLICT;
        else
            // mask is known contiguous here, so its ones count is the prefix
            outcome.prefix = 6'($countones(netmask));
        return outcome;
    endfunction

    // ------------------------------------------------------------------
    // lease generation
    // ------------------------------------------------------------------

    function automatic logic [7:0] usable_octet();
        logic [7:0] octet;
        do
            octet = 8'($urandom_range(1, 223));
        while (octet == liv_pkg::LoopOct);
        return octet;
    endfunction

    // network base: mostly ordinary space, sometimes aimed at a range that
    // the block must refuse
    function automatic logic [31:0] pick_base();
        int unsigned aim;
        aim = $urandom_range(0, 9);
        case (aim)
            0: return lan_address_now;
            1: return liv_pkg::CgnatLow | ($urandom() & 32'h003f_ffff);
            2: return liv_pkg::LinklLow | ($urandom() & 32'h0000_ffff);
            default: return {usable_octet(), 24'($urandom())};
        endcase
    endfunction

    // contiguous mask, distinct ordinary hosts for address and gateway
    function automatic lease_t shaped_lease(int unsigned prefix, logic [31:0] base);
        logic [31:0] netmask;
        logic [31:0] host_max;
        logic [31:0] addr_host;
        logic [31:0] gateway_host;
        lease_t      lease;
        netmask   = 32'hffff_ffff << (32 - prefix);
        host_max  = ~netmask;
        addr_host = $urandom_range(1, host_max - 1);
        do
            gateway_host = $urandom_range(1, host_max - 1);
        while (gateway_host == addr_host);
        lease.address = (base & netmask) | addr_host;
        lease.netmask = netmask;
        lease.gateway = (base & netmask) | gateway_host;
        return lease;
    endfunction

    function automatic lease_t random_lease();
        int unsigned shape;
        int unsigned prefix;
        int unsigned bit_pos;
        logic [7:0]  octet;
        lease_t      lease;
        shape  = $urandom_range(0, 99);
        prefix = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 30) : $urandom_range(8, 30);
        lease  = shaped_lease(prefix, pick_base());
        if (shape >= 60 && shape < 78)
        begin
            // well formed, then broken in one way the gateway check must catch
            case ($urandom_range(0, 5))
                0:
                begin
                    bit_pos = $urandom_range(32 - prefix, 31);
                    lease.gateway[bit_pos] = ~lease.gateway[bit_pos];
                end
                1: lease.gateway = lease.address;
                2: lease.address = lease.address & lease.netmask;
                3: lease.address = lease.address | ~lease.netmask;
                4: lease.gateway = ($urandom_range(0, 1) == 0) ?
                                   (lease.gateway & lease.netmask) :
                                   (lease.gateway | ~lease.netmask);
                default:
                begin
                    case ($urandom_range(0, 2))
                        0: octet = 8'd0;
                        1: octet = liv_pkg::LoopOct;
                        default: octet = 8'($urandom_range(224, 255));
                    endcase
                    lease.address[31:24] = octet;
                    lease.gateway[31:24] = octet;
                end
            endcase
        end
        else if (shape >= 78 && shape < 88)
        begin
            // masks near and far from a legal shape
            case ($urandom_range(0, 4))
                0: lease.netmask = $urandom();
                1:
                begin
                    bit_pos = $urandom_range(0, 31);
                    lease.netmask[bit_pos] = ~lease.netmask[bit_pos];
                end
                2: lease.netmask = 32'hffff_ffff;
                3: lease.netmask = 32'hffff_fffe;
                default: lease.netmask = '0;
            endcase
        end
        else if (shape >= 88)
        begin
            lease.address = $urandom();
            lease.netmask = $urandom();
            lease.gateway = $urandom();
        end
        return lease;
    endfunction

    task automatic queue_lease(logic [31:0] addr, logic [31:0] netmask, logic [31:0] gateway);
        lease_queue.push_back(lease_t'{address: addr, netmask: netmask, gateway: gateway});
    endtask

    task automatic queue_random_leases(int count);
        repeat (count) lease_queue.push_back(random_lease());
    endtask

    // ------------------------------------------------------------------
    // sequencing helpers
    // ------------------------------------------------------------------

    // idle: nothing left to offer, nothing on the port, no verdict owed;
    // looked at on the falling edge so the driver has settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (lease_queue.size() != 0 || start || verdict_queue.size() != 0);
    endtask

    task automatic write_cfg(logic index, logic [31:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (index == liv_pkg::CfgLanAddress)
            lan_address_now = data;
        else
            lan_netmask_now = data;
    endtask

    // drain, reprogram the lan subnet, then set the sender's idling for the phase
    task automatic switch_lan(logic [31:0] addr, logic [31:0] netmask, int pct);
        wait_idle();
        write_cfg(liv_pkg::CfgLanAddress, addr);
        write_cfg(liv_pkg::CfgLanNetmask, netmask);
        @(negedge clk);
        idle_pct = pct;
    endtask

    // ------------------------------------------------------------------
    // driver: offers leases from lease_queue, predicts on each transfer
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        lease_t next_lease;
        logic   next_start;
        if (!rst_n)
        begin
            start           <= 1'b0;
            lease_address   <= '0;
            lease_netmask   <= '0;
            gateway_address <= '0;
            idle_left = 0;
        end
        else
        begin
            // transfer at this edge: the fields on the port are what was taken
            if (start && !busy)
                verdict_queue.push_back(judge_lease(lease_address, lease_netmask,
                                                    gateway_address));
            // a lease held off by busy stays on the port untouched
            if (!(start && busy))
            begin
                next_start = 1'b0;
                next_lease = '{address: lease_address, netmask: lease_netmask,
                               gateway: gateway_address};
                if (idle_left > 0)
                    idle_left--;
                else if (lease_queue.size() != 0)
                begin
                    // idle burst of random length, counted down in idle_left
                    if ($urandom_range(0, 99) < idle_pct)
                        idle_left = $urandom_range(0, 3);
                    else
                    begin
                        next_lease = lease_queue.pop_front();
                        next_start = 1'b1;
                    end
                end
                start           <= next_start;
                lease_address   <= next_lease.address;
                lease_netmask   <= next_lease.netmask;
                gateway_address <= next_lease.gateway;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: each done pulse is checked against the oldest owed verdict
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        lease_verdict_t want;
        if (rst_n && done)
        begin
            if (verdict_queue.size() == 0)
            begin
                $error("unexpected result: verdict %0d prefix_length %0d",
                       verdict, prefix_length);
                error_count++;
            end
            else
            begin
                want = verdict_queue.pop_front();
                if (verdict !== want.verdict)
                begin
                    $error("verdict: expected %0d, actual %0d", want.verdict, verdict);
                    error_count++;
                end
                if (prefix_length !== want.prefix)
                begin
                    $error("prefix_length: expected %0d, actual %0d",
                           want.prefix, prefix_length);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CycleLimit)
        begin
            $display("ipv4_lease_validator regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus phases
    // ------------------------------------------------------------------
    initial
    begin
        idle_pct = 30;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // lan at reset: 192.168.1.0/24
        // ordinary valid leases, including a /3 prefix and the longest, /30
        queue_lease(32'h0a00_0005, 32'hffff_ff00, 32'h0a00_0001);
        queue_lease(32'h0a00_0101, 32'hffff_fffc, 32'h0a00_0102);
        queue_lease(32'h0b12_3456, 32'hff00_0000, 32'h0b00_0001);
        queue_lease(32'h2000_0001, 32'he000_0000, 32'h3fff_fffe);
        queue_lease(32'hdf00_0005, 32'hffff_ff00, 32'hdf00_0001);
        // bad masks: zero, all ones, one host bit, holes, top bit clear
        queue_lease(32'h0a00_0005, 32'h0000_0000, 32'h0a00_0001);
        queue_lease(32'h0a00_0005, 32'hffff_ffff, 32'h0a00_0001);
        queue_lease(32'h0a00_0005, 32'hffff_fffe, 32'h0a00_0004);
        queue_lease(32'h0a00_0005, 32'hffff_00ff, 32'h0a00_0001);
        queue_lease(32'h0a00_0005, 32'h7fff_ff00, 32'h0a00_0001);
        // gateway faults: other subnet, same as address, network and broadcast hosts
        queue_lease(32'h0a00_0005, 32'hffff_ff00, 32'h0a00_0105);
        queue_lease(32'h0a00_0005, 32'hffff_ff00, 32'h0a00_0005);
        queue_lease(32'h0a00_0000, 32'hffff_ff00, 32'h0a00_0001);
        queue_lease(32'h0a00_00ff, 32'hffff_ff00, 32'h0a00_0001);
        queue_lease(32'h0a00_0005, 32'hffff_ff00, 32'h0a00_0000);
        queue_lease(32'h0a00_0005, 32'hffff_ff00, 32'h0a00_00ff);
        // reserved first octets: zero, loopback, multicast, top of space
        queue_lease(32'h0000_0105, 32'hffff_ff00, 32'h0000_0101);
        queue_lease(32'h7f00_0005, 32'hffff_ff00, 32'h7f00_0001);
        queue_lease(32'he000_0005, 32'hffff_ff00, 32'he000_0001);
        queue_lease(32'hff00_0005, 32'hffff_ff00, 32'hff00_0001);
        // overlaps with the lan, shared address space and link-local, and just past
        queue_lease(32'hc0a8_0105, 32'hffff_ff00, 32'hc0a8_0101);
        queue_lease(32'h647f_ff05, 32'hffff_ff00, 32'h647f_ff01);
        queue_lease(32'h6480_0005, 32'hffff_ff00, 32'h6480_0001);
        queue_lease(32'ha9fe_0005, 32'hffff_ff00, 32'ha9fe_0001);
        // all-ones and all-zeros fields
        queue_lease(32'hffff_ffff, 32'hffff_ff00, 32'h0000_0000);
        queue_random_leases(260);

        // every sender pause here waits out all owed verdicts first
        switch_lan(32'h0a00_0001, 32'hff00_0000, 0);
        queue_random_leases(285);

        // lan mask of zero covers all of the address space
        switch_lan(32'h0000_0000, 32'h0000_0000, 50);
        queue_random_leases(285);

        switch_lan(32'hffff_ffff, 32'hffff_ffff, 20);
        queue_random_leases(285);

        // mask with holes: only its span from low to high counts
        switch_lan(32'hc0a8_0101, 32'hff00_ff00, 35);
        queue_lease(32'hc050_0005, 32'hffff_ff00, 32'hc050_0001);
        queue_random_leases(285);

        // closing stretch with no idling
        switch_lan(32'hac10_0001, 32'hfff0_0000, 0);
        queue_random_leases(285);

        wait_idle();
        // room for any stray done pulse
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("ipv4_lease_validator regression: pass");
        else
            $display("ipv4_lease_validator regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
rtl/liv_pkg.sv
rtl/liv_mask_check.sv
rtl/liv_lease_eval.sv
rtl/ipv4_lease_validator.sv
rtl/liv_checker.sv
tb/ipv4_lease_validator_tb.sv
